>>> rtl/core/rarm_pkg.sv
// ----------------------------------------------------------------------------
// rarm_pkg: shared types and constants
// Request field widths, function codes and sequencer types for the range
// add / range membership unit.
// ----------------------------------------------------------------------------
package rarm_pkg;

   // request and response field widths
   localparam int FUNC_W  = 2;
   localparam int LEFT_W  = 10;
   localparam int RIGHT_W = 11;
   localparam int DATA_W  = 32;

   // function codes (code 3 is ignored)
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL,
      ST_SPLIT,
      ST_RUN,
      ST_DRAIN,
      ST_RESULT
   } rarm_state_type;

   // operation held in the write-back stage
   typedef enum logic [1:0] {
      OP_ELEM_ADD,
      OP_OFF_ADD,
      OP_LOAD,
      OP_QUERY
   } rarm_op_type;

endpackage

>>> rtl/core/rarm_req_if.sv
// ----------------------------------------------------------------------------
// rarm_req_if: request channel
// Valid/ready channel carrying one load, range add or query request.
// ----------------------------------------------------------------------------
interface rarm_req_if;
   logic                                valid;
   logic                                ready;
   logic [rarm_pkg::FUNC_W-1:0]         func;
   logic [rarm_pkg::LEFT_W-1:0]         left;
   logic [rarm_pkg::RIGHT_W-1:0]        right;
   logic signed [rarm_pkg::DATA_W-1:0]  value;

   modport source (output valid, func, left, right, value, input ready);
   modport sink   (input valid, func, left, right, value, output ready);
endinterface

>>> rtl/core/rarm_rsp_if.sv
// ----------------------------------------------------------------------------
// rarm_rsp_if: response channel
// Valid/ready channel carrying the found flag of one query.
// ----------------------------------------------------------------------------
interface rarm_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, found, input ready);
   modport sink   (input valid, found, output ready);
endinterface

>>> rtl/core/rarm_ram.sv
// ----------------------------------------------------------------------------
// rarm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rarm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/range_add_range_membership_unit.sv
// ----------------------------------------------------------------------------
// range_add_range_membership_unit: blocked array with lazy block offsets
// Element words and per-block offsets live in two RAMs; a sequencer walks
// a range one element or one whole block per cycle, read then write back.
// ----------------------------------------------------------------------------
// Sequence: after accept a request passes ST_MUL, ST_SPLIT, ST_RUN and ST_DRAIN,
//   and a query then ST_RESULT, held there while an earlier response still
//   waits. In ST_RUN a load makes a single write, an add updates partial-block
//   elements singly and whole blocks by their offset, and a query visits every element.
// Throughput: one request at a time; one RAM step per cycle, bounded by the
//   single read port of each RAM.
// Reset: synchronous; a clearing pass zeroes both RAMs, and req_chan.ready
//   stays low until it completes.
// ----------------------------------------------------------------------------
module range_add_range_membership_unit #(
   parameter int ELEMENTS   = 1024,
   parameter int BLOCK_SIZE = 32,
   parameter int BLOCKS     = 32
) (
   input logic         clock,
   input logic         reset,
   rarm_req_if.sink    req_chan,
   rarm_rsp_if.source  rsp_chan
);
   import rarm_pkg::*;

   // derived sizes
   localparam int IDX_W   = $clog2(ELEMENTS);
   localparam int CNT_W   = $clog2(ELEMENTS + 1);
   localparam int CMP_W   = (CNT_W > RIGHT_W) ? CNT_W : RIGHT_W;
   localparam int NBLK    = (ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int QMAX    = ((1 << LEFT_W) - 1) / BLOCK_SIZE;
   localparam int BMAX_A  = (NBLK > BLOCKS) ? NBLK : BLOCKS;
   localparam int BMAX    = (BMAX_A > QMAX) ? BMAX_A : QMAX;
   localparam int BW      = $clog2(BMAX + 1);
   localparam int OA_W    = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int PS_W    = $clog2(BLOCK_SIZE);
   localparam int CLR_N   = (ELEMENTS > BLOCKS) ? ELEMENTS : BLOCKS;
   localparam int CL_W    = (CLR_N > 1) ? $clog2(CLR_N) : 1;
   // reciprocal for left / BLOCK_SIZE, exact over all LEFT_W-bit values
   localparam int MUL_S   = LEFT_W + $clog2(BLOCK_SIZE);
   localparam int MUL_M   = ((1 << MUL_S) + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int PW      = LEFT_W + MUL_S + 1;

   // control state
   rarm_state_type        state_ff, state_in;
   logic [CL_W-1:0]       clr_ff, clr_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // request fields and walk state
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic [LEFT_W-1:0]     left_ff, left_in;
   logic [CMP_W-1:0]      hi_ff, hi_in;
   logic [DATA_W-1:0]     value_ff, value_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [CMP_W-1:0]      i_ff, i_in;
   logic [BW-1:0]         blk_ff, blk_in;
   logic [PS_W-1:0]       pos_ff, pos_in;
   logic                  found_ff, found_in;
   logic                  rsp_found_ff, rsp_found_in;

   // write-back stage
   rarm_op_type           s1_op_ff, s1_op_in;
   logic [IDX_W-1:0]      s1_eaddr_ff, s1_eaddr_in;
   logic [OA_W-1:0]       s1_oaddr_ff, s1_oaddr_in;
   logic                  s1_has_off_ff, s1_has_off_in;

   // RAM ports
   logic                  e_we, o_we;
   logic [IDX_W-1:0]      e_waddr;
   logic [OA_W-1:0]       o_waddr;
   logic [DATA_W-1:0]     e_wdata, o_wdata, e_rdata, o_rdata;

   // helpers
   logic [CMP_W-1:0]      lo_ext, right_ext;
   logic [CMP_W:0]        i_plus_bs;
   logic [BW-1:0]         quot;
   logic [CMP_W-1:0]      pos_full;
   logic                  blk_has_off;
   logic                  whole_blk;
   logic                  clr_elem, clr_off;
   logic [DATA_W-1:0]     off_eff;
   logic                  hit;

   assign lo_ext      = CMP_W'(left_ff);
   assign right_ext   = CMP_W'(req_chan.right);
   assign i_plus_bs   = (CMP_W+1)'(i_ff) + (CMP_W+1)'(BLOCK_SIZE);
   assign quot        = BW'(prod_ff >> MUL_S);
   assign pos_full    = lo_ext - CMP_W'(quot) * CMP_W'(BLOCK_SIZE);
   assign blk_has_off = {1'b0, blk_ff} < (BW+1)'(BLOCKS);
   assign whole_blk   = (func_ff == FUNC_ADD) && (pos_ff == '0) &&
                        (i_plus_bs <= (CMP_W+1)'(hi_ff)) && blk_has_off;
   assign clr_elem    = {1'b0, clr_ff} < (CL_W+1)'(ELEMENTS);
   assign clr_off     = {1'b0, clr_ff} < (CL_W+1)'(BLOCKS);
   assign off_eff     = s1_has_off_ff ? o_rdata : '0;
   assign hit         = s1_valid_ff && (s1_op_ff == OP_QUERY) &&
                        ((e_rdata + off_eff) == value_ff);

   // element words and block offsets
   rarm_ram #(.WIDTH(DATA_W), .DEPTH(ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_addr (i_ff[IDX_W-1:0]),
      .rd_data (e_rdata)
   );

   rarm_ram #(.WIDTH(DATA_W), .DEPTH(BLOCKS)) u_off_ram (
      .clock   (clock),
      .wr_en   (o_we),
      .wr_addr (o_waddr),
      .wr_data (o_wdata),
      .rd_addr (blk_ff[OA_W-1:0]),
      .rd_data (o_rdata)
   );

   // RAM write ports: clearing pass, else write-back stage
   always_comb begin
      e_we    = 1'b0;
      o_we    = 1'b0;
      e_waddr = s1_eaddr_ff;
      o_waddr = s1_oaddr_ff;
      e_wdata = '0;
      o_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         e_we    = clr_elem;
         o_we    = clr_off;
         e_waddr = clr_ff[IDX_W-1:0];
         o_waddr = clr_ff[OA_W-1:0];
      end else if (s1_valid_ff) begin
         unique case (s1_op_ff)
            OP_ELEM_ADD: begin
               e_we    = 1'b1;
               e_wdata = e_rdata + value_ff;
            end
            OP_OFF_ADD: begin
               o_we    = 1'b1;
               o_wdata = o_rdata + value_ff;
            end
            OP_LOAD: begin
               e_we    = 1'b1;
               e_wdata = value_ff - off_eff;
            end
            OP_QUERY: begin
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: next state and walk control
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      func_in       = func_ff;
      left_in       = left_ff;
      hi_in         = hi_ff;
      value_in      = value_ff;
      prod_in       = prod_ff;
      i_in          = i_ff;
      blk_in        = blk_ff;
      pos_in        = pos_ff;
      found_in      = found_ff | hit;
      s1_valid_in   = 1'b0;
      s1_op_in      = s1_op_ff;
      s1_eaddr_in   = i_ff[IDX_W-1:0];
      s1_oaddr_in   = blk_ff[OA_W-1:0];
      s1_has_off_in = blk_has_off;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in  = rsp_found_ff;
      req_chan.ready = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CL_W'(1);
            if (clr_ff == CL_W'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               func_in  = req_chan.func;
               left_in  = req_chan.left;
               value_in = $unsigned(req_chan.value);
               hi_in    = (right_ext > CMP_W'(ELEMENTS)) ? CMP_W'(ELEMENTS) : right_ext;
               found_in = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PW'(left_ff) * PW'(MUL_M);
            state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            blk_in   = quot;
            pos_in   = pos_full[PS_W-1:0];
            i_in     = lo_ext;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            priority if (func_ff == FUNC_LOAD) begin
               // single write of value minus the block offset
               s1_valid_in = (lo_ext < CMP_W'(ELEMENTS));
               s1_op_in    = OP_LOAD;
               state_in    = ST_DRAIN;
            end else if (((func_ff == FUNC_ADD) || (func_ff == FUNC_QUERY)) &&
                         (i_ff < hi_ff)) begin
               s1_valid_in = 1'b1;
               if (whole_blk) begin
                  // whole block: bump its offset, skip to next block
                  s1_op_in = OP_OFF_ADD;
                  i_in     = CMP_W'(i_plus_bs);
                  blk_in   = blk_ff + BW'(1);
               end else begin
                  s1_op_in = (func_ff == FUNC_ADD) ? OP_ELEM_ADD : OP_QUERY;
                  i_in     = i_ff + CMP_W'(1);
                  if (pos_ff == PS_W'(BLOCK_SIZE - 1)) begin
                     pos_in = '0;
                     blk_in = blk_ff + BW'(1);
                  end else begin
                     pos_in = pos_ff + PS_W'(1);
                  end
               end
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = (func_ff == FUNC_QUERY) ? ST_RESULT : ST_IDLE;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      left_ff       <= left_in;
      hi_ff         <= hi_in;
      value_ff      <= value_in;
      prod_ff       <= prod_in;
      i_ff          <= i_in;
      blk_ff        <= blk_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      rsp_found_ff  <= rsp_found_in;
      s1_op_ff      <= s1_op_in;
      s1_eaddr_ff   <= s1_eaddr_in;
      s1_oaddr_ff   <= s1_oaddr_in;
      s1_has_off_ff <= s1_has_off_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.found = rsp_found_ff;

   // no write-back may be pending when a new request can enter
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !s1_valid_ff)
      else $error("write-back pending while accepting a request");

   // a response is only raised from the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result state");

   // query compares only occur for query requests
   a_query_op: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_op_ff == OP_QUERY)) |-> (func_ff == FUNC_QUERY))
      else $error("query compare for a non-query request");

   // offset updates only come from range adds on a tracked block
   a_off_add: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_op_ff == OP_OFF_ADD)) |->
         ((func_ff == FUNC_ADD) && s1_has_off_ff))
      else $error("offset update outside a range add");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for range_add_range_membership_unit
// Drives loads, range adds, range queries and ignored requests through the
// request channel, tracks the element array and block offsets in a local
// model, and checks every found flag on the response channel in order.
// Both channels idle in random bursts; the response side also holds off
// twice for a long stretch so that the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import rarm_pkg::*;

   localparam int ELEMENTS   = 1024;
   localparam int BLOCK_SIZE = 32;
   localparam int BLOCKS     = 32;

   localparam logic [FUNC_W-1:0] FUNC_IGNORED = 2'd3;

   localparam int RANDOM_REQUESTS = 550;
   localparam int QUIET_TAIL      = 110;
   localparam int LONG_HOLD       = 400;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [LEFT_W-1:0]         left;
      logic [RIGHT_W-1:0]        right;
      logic signed [DATA_W-1:0]  value;
   } request_type;

   typedef struct packed {
      logic        found;
      request_type query;
   } found_expect_type;

   logic clock;
   logic reset;

   rarm_req_if req_chan ();
   rarm_rsp_if rsp_chan ();

   range_add_range_membership_unit #(
      .ELEMENTS   (ELEMENTS),
      .BLOCK_SIZE (BLOCK_SIZE),
      .BLOCKS     (BLOCKS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // local copy of the array state
   bit [DATA_W-1:0] element_word [ELEMENTS];
   bit [DATA_W-1:0] block_offset [BLOCKS];

   request_type      pending_requests [$];
   found_expect_type found_expected [$];

   int requests_issued;
   int requests_accepted;
   int send_gap;
   int stall_left;
   int hold_left;
   int long_hold_requests;
   int long_holds_started;
   bit idle_bursts_on;

   int mismatch_count;
   int load_count;
   int add_count;
   int block_offset_updates;
   int query_count;
   int hit_count;
   int ignored_count;

   // clock and initial drive of every input
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.func  = '0;
      req_chan.left  = '0;
      req_chan.right = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [DATA_W-1:0] offset_of(int blk);
      return (blk < BLOCKS) ? block_offset[blk] : '0;
   endfunction

   // value an element holds: stored word plus its block's pending offset
   function automatic logic [DATA_W-1:0] held_value(int idx);
      return element_word[idx] + offset_of(idx / BLOCK_SIZE);
   endfunction

   function automatic request_type make_request(logic [FUNC_W-1:0] func, int left, int right,
                                                logic [DATA_W-1:0] value);
      request_type r;
      r.func  = func;
      r.left  = LEFT_W'(left);
      r.right = RIGHT_W'(right);
      r.value = value;
      return r;
   endfunction

   // update the array for one accepted request; queue the found flag of a query
   task automatic apply_request(request_type r);
      int lo, hi, idx, blk, blk_start, blk_stop;
      logic hit;
      lo = r.left;
      hi = r.right;
      if (hi > ELEMENTS) hi = ELEMENTS;
      case (r.func)
         FUNC_LOAD: begin
            if (lo < ELEMENTS) element_word[lo] = r.value - offset_of(lo / BLOCK_SIZE);
            load_count++;
         end
         FUNC_ADD: begin
            idx = lo;
            while (idx < hi) begin
               blk       = idx / BLOCK_SIZE;
               blk_start = blk * BLOCK_SIZE;
               blk_stop  = blk_start + BLOCK_SIZE;
               if (idx == blk_start && blk_stop <= hi && blk < BLOCKS) begin
                  // whole block covered: raise its lazy offset
                  block_offset[blk] += r.value;
                  block_offset_updates++;
                  idx = blk_stop;
               end else begin
                  element_word[idx] += r.value;
                  idx++;
               end
            end
            add_count++;
         end
         FUNC_QUERY: begin
            hit = 1'b0;
            for (idx = lo; idx < hi && !hit; idx++)
               if (held_value(idx) == r.value) hit = 1'b1;
            found_expected.push_back('{found: hit, query: r});
            query_count++;
            if (hit) hit_count++;
         end
         default: begin
            ignored_count++;
         end
      endcase
   endtask

   // request side: offer the next queued request once the previous one is taken
   always @(negedge clock) begin
      request_type next_req;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (requests_issued == requests_accepted) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            next_req = pending_requests.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.func  <= next_req.func;
            req_chan.left  <= next_req.left;
            req_chan.right <= next_req.right;
            req_chan.value <= next_req.value;
            requests_issued++;
            if (idle_bursts_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response side: long hold when asked, else random stall bursts
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (long_holds_started < long_hold_requests) begin
         long_holds_started++;
         hold_left = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (idle_bursts_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 7) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      found_expect_type exp;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            apply_request(make_request(req_chan.func, req_chan.left, req_chan.right,
                                       req_chan.value));
            requests_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (found_expected.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response: expected none, actual found=%0b",
                        $time, rsp_chan.found);
            end else begin
               exp = found_expected.pop_front();
               if (rsp_chan.found !== exp.found) begin
                  mismatch_count++;
                  $display("%0t: query [%0d,%0d) value %h: expected found %0b, actual %0b",
                           $time, exp.query.left, exp.query.right, exp.query.value,
                           exp.found, rsp_chan.found);
               end
            end
         end
      end
   end

   // keep the request queue short so query values track the current array
   task automatic send_request(request_type r);
      while (pending_requests.size() >= 2) @(posedge clock);
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || requests_issued != requests_accepted ||
             found_expected.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_random_request();
      request_type r;
      int kind, lo, hi;
      kind    = $urandom_range(0, 99);
      r.value = $urandom;
      r.left  = LEFT_W'($urandom_range(0, ELEMENTS - 1));
      // range shape: mostly short, some block aligned, some whole array or empty
      case ($urandom_range(0, 9))
         0: begin
            r.left  = LEFT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0);
            r.right = RIGHT_W'($urandom_range(ELEMENTS, 2047));
         end
         1: begin
            r.left  = LEFT_W'($urandom_range(0, BLOCKS - 1) * BLOCK_SIZE);
            r.right = RIGHT_W'(r.left + BLOCK_SIZE * $urandom_range(1, 4));
         end
         2: r.right = RIGHT_W'($urandom_range(0, r.left));
         3, 4: r.right = RIGHT_W'(r.left + $urandom_range(1, 200));
         default: r.right = RIGHT_W'(r.left + $urandom_range(1, 40));
      endcase
      lo = r.left;
      hi = (r.right > ELEMENTS) ? ELEMENTS : r.right;
      if (kind < 30) begin
         r.func = FUNC_LOAD;
         if ($urandom_range(0, 1) == 0) r.value = $urandom_range(0, 15) - 8;
      end else if (kind < 55) begin
         r.func = FUNC_ADD;
         if ($urandom_range(0, 1) == 0) r.value = $urandom_range(0, 6) - 3;
      end else if (kind < 96) begin
         r.func = FUNC_QUERY;
         // mostly search for a value that some element in range holds
         if (lo < hi && $urandom_range(0, 9) < 6)
            r.value = held_value($urandom_range(lo, hi - 1));
         else if ($urandom_range(0, 1) == 0)
            r.value = $urandom_range(0, 15) - 8;
      end else begin
         r.func = FUNC_IGNORED;
      end
      send_request(r);
   endtask

   // stimulus
   initial begin
      idle_bursts_on = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, clamping, empty ranges, ignored code, offsets
      send_request(make_request(FUNC_LOAD,  0,    0,    32'h7fff_ffff));
      send_request(make_request(FUNC_LOAD,  1023, 0,    32'h8000_0000));
      send_request(make_request(FUNC_LOAD,  517,  2047, 32'hffff_ffff));
      send_request(make_request(FUNC_QUERY, 0,    1024, 32'h7fff_ffff));
      send_request(make_request(FUNC_QUERY, 1,    1023, 32'h7fff_ffff));
      send_request(make_request(FUNC_QUERY, 1023, 2047, 32'h8000_0000));
      send_request(make_request(FUNC_QUERY, 10,   3,    32'h0000_0000));
      send_request(make_request(FUNC_ADD,   5,    5,    32'h0000_0064));
      send_request(make_request(FUNC_ADD,   700,  2,    32'h0000_0064));
      send_request(make_request(FUNC_IGNORED, 0,  1024, 32'h1234_5678));
      send_request(make_request(FUNC_ADD,   0,    2047, 32'h0000_0001));
      send_request(make_request(FUNC_QUERY, 0,    1,    32'h8000_0000));
      send_request(make_request(FUNC_ADD,   3,    40,   32'hffff_fffb));
      send_request(make_request(FUNC_ADD,   64,   128,  32'h7fff_ffff));
      send_request(make_request(FUNC_LOAD,  70,   0,    32'h0000_002a));
      send_request(make_request(FUNC_QUERY, 64,   96,   32'h0000_002a));
      send_request(make_request(FUNC_QUERY, 0,    1024, 32'hffff_fffc));
      send_request(make_request(FUNC_ADD,   33,   1024, 32'h8000_0000));
      send_request(make_request(FUNC_QUERY, 1000, 1024, 32'h8000_0001));
      send_request(make_request(FUNC_LOAD,  1023, 0,    32'h0000_0000));
      send_request(make_request(FUNC_QUERY, 1023, 1024, 32'h0000_0000));
      send_request(make_request(FUNC_QUERY, 1022, 1023, 32'h0000_0000));

      // sender pause until every answer is back
      wait_drained();

      // long response hold while queries keep coming
      long_hold_requests++;
      repeat (8) send_request(make_request(FUNC_QUERY, $urandom_range(0, 200),
                                           $urandom_range(201, 400), $urandom_range(0, 3)));

      // random part; idle stretches vary, the tail runs without idling
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 60 == 0) idle_bursts_on = ($urandom_range(0, 3) != 0);
         if (n == RANDOM_REQUESTS / 2) long_hold_requests++;
         if (n >= RANDOM_REQUESTS - QUIET_TAIL) idle_bursts_on = 1'b0;
         send_random_request();
      end

      wait_drained();
      repeat (ELEMENTS + 16) @(posedge clock);

      $display("Covered %0d loads, %0d range adds (%0d whole-block offset updates),",
               load_count, add_count, block_offset_updates);
      $display("%0d queries with %0d hits, and %0d ignored requests.",
               query_count, hit_count, ignored_count);
      if (mismatch_count == 0) begin
         $display("PASS range_add_range_membership_unit");
      end else begin
         $display("FAIL range_add_range_membership_unit");
      end
      $finish;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("FAIL range_add_range_membership_unit");
      $finish;
   end

endmodule

>>> range_add_range_membership_unit.f
rtl/core/rarm_pkg.sv
rtl/core/rarm_req_if.sv
rtl/core/rarm_rsp_if.sv
rtl/core/rarm_ram.sv
rtl/core/range_add_range_membership_unit.sv
bench/tb.sv
